[hdl/command_line_tokenizer_top_defines.svh]
// Assertion macros for the command-line tokeniser.
// Depends on a clock named clk and an active-high reset named rst in scope.
`ifndef COMMAND_LINE_TOKENIZER_TOP_DEFINES_SVH
`define COMMAND_LINE_TOKENIZER_TOP_DEFINES_SVH

// Check a condition on every clock edge outside reset
`define CLT_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a condition implies another on the following edge
`define CLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/clt_pkg.sv]
// Types, character constants and helper functions for the command-line tokeniser.
// No dependencies.
`timescale 1ns / 1ps

package clt_pkg;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_LC_E  = 8'h65;
  localparam logic [7:0] CH_UC_E  = 8'h45;
  localparam logic [7:0] CH_LC_N  = 8'h6E;
  localparam logic [7:0] CH_UC_N  = 8'h4E;

  // Scanner mode
  typedef enum logic [2:0] {
    MODE_BETWEEN  = 3'd0,
    MODE_UNQUOTED = 3'd1,
    MODE_QUOTED   = 3'd2,
    MODE_ESCAPE   = 3'd3,
    MODE_DRAIN    = 3'd4
  } mode_t;

  // Result kind
  typedef enum logic [1:0] {
    KIND_BYTE     = 2'd0,
    KIND_END_ARG  = 2'd1,
    KIND_END_LINE = 2'd2
  } kind_t;

  // One result word
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [7:0] arg_index;
    logic [7:0] arg_total;
  } res_word_t;

  localparam int unsigned RES_SLOTS = 4;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_LF) || (c == CH_TAB) ||
           (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
  endfunction

  // Map an escaped byte to its value
  function automatic logic [7:0] unescape(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if ((c == CH_LC_E) || (c == CH_UC_E)) r = CH_ESC;
    else if ((c == CH_LC_N) || (c == CH_UC_N)) r = CH_LF;
    return r;
  endfunction

endpackage

[hdl/command_line_tokenizer_top.sv]
// Command-line tokeniser: one line byte per input word, argument bytes,
// end-of-argument and end-of-line words out. Depends on clt_pkg and the defines header.
// The first result of an input word is offered in the cycle after the word is accepted.
// Throughput: one input word per cycle while each causes at most one result and the output
// is not stalled; a word causing more results (up to four) holds the input until its last is taken.
// Reset (synchronous, rst high) clears the scanner to between arguments, count 1,
// and empties the result buffer.
`timescale 1ns / 1ps
`include "command_line_tokenizer_top_defines.svh"

module command_line_tokenizer_top
  import clt_pkg::*;
#(
  parameter int unsigned MAX_ARGS = 255
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] ch,
  input  logic       line_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] kind,
  output logic [7:0] data,
  output logic [7:0] arg_index,
  output logic [7:0] arg_total,
  output logic       run_last
);

  localparam logic [7:0] COUNT_CAP = (MAX_ARGS > 255) ? 8'd255 : 8'(MAX_ARGS);

  // Scanner state
  mode_t      mode, mode_next;
  logic       quote_pending, quote_pending_next;
  logic [7:0] arg_counter, arg_counter_next;

  // Result buffer
  res_word_t  res_buf [RES_SLOTS];
  res_word_t  res_new [RES_SLOTS];
  logic [2:0] res_left;
  logic [1:0] res_ptr;
  logic [2:0] res_count_new;

  logic       in_fire, out_fire;

  // Result flags in their fixed output order
  logic       emit_quote, emit_byte, emit_end_arg, emit_eol;
  logic [7:0] byte_value;
  logic [7:0] cnt_emit;
  logic       ended;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign in_ready = (res_left == 3'd0) || ((res_left == 3'd1) && out_ready);

  // Scan one byte: decide results and next state
  always_comb begin
    logic is_nul;
    logic ws;
    is_nul = (ch == CH_NUL);
    ws     = is_ws(ch);
    mode_next          = mode;
    quote_pending_next = quote_pending;
    arg_counter_next   = arg_counter;
    cnt_emit     = arg_counter;
    emit_quote   = 1'b0;
    emit_byte    = 1'b0;
    emit_end_arg = 1'b0;
    emit_eol     = 1'b0;
    byte_value   = ch;
    ended        = 1'b0;
    if (mode == MODE_DRAIN) begin
      // Swallow bytes until the buffer ends
      if (line_end) begin
        mode_next          = MODE_BETWEEN;
        quote_pending_next = 1'b0;
        arg_counter_next   = 8'd1;
      end
    end else begin
      case (mode)
        MODE_UNQUOTED: begin
          if (is_nul || ws) begin
            emit_end_arg = 1'b1;
            mode_next    = MODE_BETWEEN;
            quote_pending_next = 1'b0;
            ended        = is_nul;
          end else begin
            emit_byte = 1'b1;
          end
        end
        MODE_QUOTED: begin
          if (quote_pending && (is_nul || ws)) begin
            // Closing quote confirmed
            emit_end_arg = 1'b1;
            mode_next    = MODE_BETWEEN;
            quote_pending_next = 1'b0;
            ended        = is_nul;
          end else if (!quote_pending && is_nul) begin
            emit_end_arg = 1'b1;
            mode_next    = MODE_BETWEEN;
            quote_pending_next = 1'b0;
            ended        = 1'b1;
          end else begin
            // Release a held quote as a literal, then take the byte
            emit_quote         = quote_pending;
            quote_pending_next = 1'b0;
            if (ch == CH_QUOTE) begin
              quote_pending_next = 1'b1;
            end else if (ch == CH_STAR) begin
              mode_next = MODE_ESCAPE;
            end else begin
              emit_byte = 1'b1;
            end
          end
        end
        MODE_ESCAPE: begin
          if (is_nul) begin
            emit_end_arg = 1'b1;
            mode_next    = MODE_BETWEEN;
            quote_pending_next = 1'b0;
            ended        = 1'b1;
          end else begin
            emit_byte  = 1'b1;
            byte_value = unescape(ch);
            mode_next  = MODE_QUOTED;
          end
        end
        default: begin
          mode_next          = MODE_BETWEEN;
          quote_pending_next = 1'b0;
          if (is_nul) begin
            ended = 1'b1;
          end else if (!ws) begin
            // Open a new argument
            if (arg_counter < COUNT_CAP) cnt_emit = arg_counter + 8'd1;
            arg_counter_next = cnt_emit;
            if (ch == CH_QUOTE) begin
              mode_next = MODE_QUOTED;
            end else begin
              mode_next = MODE_UNQUOTED;
              emit_byte = 1'b1;
            end
          end
        end
      endcase
      // Close an open argument at the end of the buffer
      if (!ended && line_end) begin
        if ((mode_next == MODE_UNQUOTED) || (mode_next == MODE_QUOTED) ||
            (mode_next == MODE_ESCAPE)) begin
          emit_end_arg = 1'b1;
        end
        ended = 1'b1;
      end
      if (ended) begin
        emit_eol           = 1'b1;
        mode_next          = line_end ? MODE_BETWEEN : MODE_DRAIN;
        quote_pending_next = 1'b0;
        arg_counter_next   = 8'd1;
      end
    end
  end

  // Pack the raised results into consecutive slots
  always_comb begin
    res_word_t w;
    logic [2:0] n;
    n = 3'd0;
    for (int i = 0; i < RES_SLOTS; i++) begin
      res_new[i] = '{kind: KIND_BYTE, data: 8'd0, arg_index: 8'd0, arg_total: 8'd0};
    end
    w = '{kind: KIND_BYTE, data: 8'd0, arg_index: cnt_emit - 8'd1, arg_total: cnt_emit};
    if (emit_quote) begin
      w.data = CH_QUOTE;
      res_new[n[1:0]] = w;
      n = n + 3'd1;
    end
    if (emit_byte) begin
      w.data = byte_value;
      res_new[n[1:0]] = w;
      n = n + 3'd1;
    end
    if (emit_end_arg) begin
      w.kind = KIND_END_ARG;
      w.data = 8'd0;
      res_new[n[1:0]] = w;
      n = n + 3'd1;
    end
    if (emit_eol) begin
      w.kind      = KIND_END_LINE;
      w.data      = 8'd0;
      w.arg_index = cnt_emit;
      res_new[n[1:0]] = w;
      n = n + 3'd1;
    end
    res_count_new = n;
  end

  // Advance scanner state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_BETWEEN;
      quote_pending <= 1'b0;
      arg_counter   <= 8'd1;
    end else if (in_fire) begin
      mode          <= mode_next;
      quote_pending <= quote_pending_next;
      arg_counter   <= arg_counter_next;
    end
  end

  // Load or drain the result buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      res_left <= 3'd0;
      res_ptr  <= 2'd0;
    end else if (in_fire) begin
      res_left <= res_count_new;
      res_ptr  <= 2'd0;
    end else if (out_fire) begin
      res_left <= res_left - 3'd1;
      res_ptr  <= res_ptr + 2'd1;
    end
  end

  // Hold result payloads
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_buf <= res_new;
    end
  end

  // Drive the output word
  assign out_valid = (res_left != 3'd0);
  assign kind      = res_buf[res_ptr].kind;
  assign data      = res_buf[res_ptr].data;
  assign arg_index = res_buf[res_ptr].arg_index;
  assign arg_total = res_buf[res_ptr].arg_total;
  assign run_last  = (res_left == 3'd1);

  `CLT_ASSERT_ALWAYS(a_left_bound, res_left <= 3'd4, "result buffer count out of range")
  `CLT_ASSERT_ALWAYS(a_count_range, (arg_counter != 8'd0) && (arg_counter <= COUNT_CAP), "argument count out of range")
  `CLT_ASSERT_ALWAYS(a_eol_last, !(out_valid && (kind == KIND_END_LINE)) || run_last, "end of line not the last result")
  `CLT_ASSERT_ALWAYS(a_no_overrun, !(in_fire && out_valid) || (out_ready && run_last), "input taken over pending results")
  `CLT_ASSERT_NEXT(a_drain_empty, out_fire && run_last && !in_fire, !out_valid, "buffer not empty after last result")

endmodule
